// ===== hw/rtl/deque_with_indexed_access_top_macros.svh =====
// assertion macros for the deque block
`ifndef DEQUE_WITH_INDEXED_ACCESS_TOP_MACROS_SVH
`define DEQUE_WITH_INDEXED_ACCESS_TOP_MACROS_SVH
`ifndef SYNTH
`define DQ_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define DQ_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define DQ_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define DQ_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== hw/rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// types and constants shared by the deque block
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAP_DEFAULT = 64;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_RESIZE     = 3'd4,
        CMD_READ       = 3'd5,
        CMD_WRITE      = 3'd6,
        CMD_DUMP       = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_READ  = 3'd0,
        ST_DUMP  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_BAD   = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] value;
        logic [5:0]  position;
        logic [6:0]  new_length;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_FILL = 2'd1,
        BK_DUMP = 2'd2
    } bk_state_t;

endpackage

// ===== hw/rtl/dq_if.sv =====
// ----------------------------------------------------------------------------
// dq_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface dq_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dq_front.sv =====
// ----------------------------------------------------------------------------
// dq_front
// two-entry command queue toward the execution side
// ----------------------------------------------------------------------------
module dq_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dq_pkg::in_item_t in_item,
    output logic             q_valid,
    input  logic             q_ready,
    output dq_pkg::in_item_t q_item
);
    import dq_pkg::*;

    in_item_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    `include "deque_with_indexed_access_top_macros.svh"
    `DQ_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "queue count overflow")
    `DQ_ASSERT_NEXT(a_full_hold, clk, rst_n, cnt_reg == 2'd2 && !pop, cnt_reg == 2'd2, "full lost")
    `DQ_ASSERT_IMPL(a_ptr_cnt, clk, rst_n, cnt_reg == 2'd0, wp_reg == rp_reg, "ptr mismatch")
endmodule

// ===== hw/rtl/dq_back.sv =====
// ----------------------------------------------------------------------------
// dq_back
// executes deque commands on the ring store and drives results
// ----------------------------------------------------------------------------
module dq_back #(
    parameter int CAPACITY = dq_pkg::CAP_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  dq_pkg::in_item_t  q_item,
    output logic              out_valid,
    input  logic              out_ready,
    output dq_pkg::out_item_t out_item
);
    import dq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [AW:0]   CAP_A = (AW+1)'(CAPACITY);

    logic [31:0] store [CAPACITY];

    bk_state_t   st_reg, st_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] tgt_reg, tgt_next;

    // output register and pending read
    logic          ov_reg, ov_next;
    out_item_t     ob_reg, ob_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [2:0]    rd_st_reg, rd_st_next;
    logic          rd_last_reg, rd_last_next;
    logic [31:0]   rdata_reg;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata;
    logic          out_free, take;
    cmd_t          cmd;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [AW+1:0] s;
        s = {2'b00, h} + {{(AW+2-CW){1'b0}}, i};
        if (s >= {1'b0, CAP_A})
        begin
            s = s - {1'b0, CAP_A};
        end
        return s[AW-1:0];
    endfunction

    assign cmd       = q_item.command;
    assign out_valid = ov_reg;
    assign out_item  = ob_reg;
    // output slot can accept new data this cycle
    assign out_free  = !ov_reg || out_ready;

    always_comb
    begin
        st_next      = st_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        tgt_next     = tgt_reg;
        ov_next      = ov_reg && !out_ready;
        ob_next      = ob_reg;
        rd_pend_next = 1'b0;
        rd_st_next   = rd_st_reg;
        rd_last_next = rd_last_reg;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = '0;
        raddr        = '0;
        wdata        = '0;
        q_ready      = 1'b0;
        take         = 1'b0;

        if (rd_pend_reg)
        begin
            ov_next = 1'b1;
            ob_next = '{data: rdata_reg, status: rd_st_reg, last: rd_last_reg};
        end

        unique case (st_reg)
            BK_IDLE:
            begin
                // a pending read occupies the output slot next cycle
                q_ready = out_free && !rd_pend_reg;
                take    = q_valid && q_ready;
                if (take)
                begin
                    unique case (cmd)
                        CMD_PUSH_BACK, CMD_PUSH_FRONT:
                        begin
                            if (count_reg >= CAP_C)
                            begin
                                ov_next = 1'b1;
                                ob_next = '{data: '0, status: ST_FULL, last: 1'b1};
                            end
                            else
                            begin
                                we    = 1'b1;
                                wdata = q_item.value;
                                if (cmd == CMD_PUSH_BACK)
                                begin
                                    waddr = slot(head_reg, count_reg);
                                end
                                else
                                begin
                                    waddr     = slot(head_reg, CW'(CAPACITY - 1));
                                    head_next = waddr;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next  = slot(head_reg, CW'(1));
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_RESIZE:
                        begin
                            if ({1'b0, q_item.new_length} > 8'(CAPACITY))
                            begin
                                ov_next = 1'b1;
                                ob_next = '{data: '0, status: ST_BAD, last: 1'b1};
                            end
                            else if (CW'(q_item.new_length) > count_reg)
                            begin
                                idx_next = count_reg;
                                tgt_next = CW'(q_item.new_length);
                                st_next  = BK_FILL;
                            end
                            else
                            begin
                                count_next = CW'(q_item.new_length);
                            end
                        end
                        CMD_READ, CMD_WRITE:
                        begin
                            if ({1'b0, q_item.position} >= 7'(count_reg))
                            begin
                                ov_next = 1'b1;
                                ob_next = '{data: '0, status: ST_BAD, last: 1'b1};
                            end
                            else if (cmd == CMD_READ)
                            begin
                                re           = 1'b1;
                                raddr        = slot(head_reg, CW'(q_item.position));
                                rd_pend_next = 1'b1;
                                rd_st_next   = ST_READ;
                                rd_last_next = 1'b1;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = slot(head_reg, CW'(q_item.position));
                                wdata = q_item.value;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                ov_next = 1'b1;
                                ob_next = '{data: '0, status: ST_EMPTY, last: 1'b1};
                            end
                            else
                            begin
                                idx_next = '0;
                                st_next  = BK_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_FILL:
            begin
                we       = 1'b1;
                waddr    = slot(head_reg, idx_reg);
                wdata    = '0;
                idx_next = idx_reg + 1'b1;
                if (idx_next == tgt_reg)
                begin
                    count_next = tgt_reg;
                    st_next    = BK_IDLE;
                end
            end
            BK_DUMP:
            begin
                if (out_free && !rd_pend_reg)
                begin
                    re           = 1'b1;
                    raddr        = slot(head_reg, idx_reg);
                    rd_pend_next = 1'b1;
                    rd_st_next   = ST_DUMP;
                    rd_last_next = (idx_reg + 1'b1 == count_reg);
                    idx_next     = idx_reg + 1'b1;
                    if (idx_next == count_reg)
                    begin
                        st_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= BK_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            tgt_reg     <= '0;
            ov_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            tgt_reg     <= tgt_next;
            ov_reg      <= ov_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg      <= ob_next;
        rd_st_reg   <= rd_st_next;
        rd_last_reg <= rd_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store[raddr];
        end
    end

    `include "deque_with_indexed_access_top_macros.svh"
    `DQ_ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_reg <= CAP_C, "count beyond capacity")
    `DQ_ASSERT_IMPL(a_pend_free, clk, rst_n, rd_pend_reg, !ov_reg || out_ready, "read overruns output")
    `DQ_ASSERT_IMPL(a_dump_nonempty, clk, rst_n, st_reg == BK_DUMP, idx_reg < count_reg, "dump index")
    `DQ_ASSERT_NEXT(a_fill_grow, clk, rst_n, st_reg == BK_FILL, count_reg == $past(count_reg) || st_reg == BK_IDLE, "fill count")
endmodule

// ===== hw/rtl/deque_with_indexed_access_top.sv =====
// ----------------------------------------------------------------------------
// deque_with_indexed_access_top
// bounded double-ended queue of 32-bit words with indexed read and write
// ----------------------------------------------------------------------------
// channel   dir   payload
// cmd_in    in    command, value, position, new_length
// res_out   out   data, status, last
//
// push, pop, write and failed commands finish in the idle state of the back part
// read passes through the registered store port and then the output register
// dump reads one element at a time through the store port; growing resize zeroes each added slot in turn
// a two-entry command queue keeps accepting while the back part is busy, until both entries are full
// reset clears head and count; store contents are undefined until written
module deque_with_indexed_access_top #(
    parameter int CAPACITY = dq_pkg::CAP_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    dq_if.sink   cmd_in,
    dq_if.source res_out
);
    import dq_pkg::*;

    logic     q_valid, q_ready;
    in_item_t q_item;

    dq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_in.valid),
        .in_ready (cmd_in.ready),
        .in_item  (cmd_in.payload),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    dq_back #(.CAPACITY(CAPACITY)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_item  (res_out.payload)
    );
endmodule

// ===== verif/deque_with_indexed_access_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_indexed_access_top_tb
// self-checking bench for the deque block: a directed command table, then
// random command mixes under several idle and stall phases, every result
// compared against an in-bench deque model
// ----------------------------------------------------------------------------
module deque_with_indexed_access_top_tb;
    import dq_pkg::*;

    localparam int CAP = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        cmd_t        command;
        logic [31:0] value;
        logic [5:0]  position;
        logic [6:0]  new_length;
        bit          has_known;
        out_item_t   known;
    } cmd_row_t;

    logic clk;
    logic rst_n;

    dq_if #(.payload_t(in_item_t))  cmd_in ();
    dq_if #(.payload_t(out_item_t)) res_out ();

    deque_with_indexed_access_top #(.CAPACITY(CAP)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_in(cmd_in.sink),
        .res_out(res_out.source)
    );

    logic [31:0] ring [CAP];
    logic [5:0]  head;
    logic [6:0]  count;
    out_item_t   expected_q [$];
    int          got_count = 0;
    int          errors = 0;
    int          table_errors;
    int          idle_cycles = 0;
    int          send_idle_pct;
    int          stall_pct;
    cmd_row_t    rows [$];

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic out_item_t mk_result(logic [31:0] d, status_t s, logic l);
        out_item_t r;
        r.data = d;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    function automatic void add_expected(out_item_t r);
        expected_q = {expected_q, r};
    endfunction

    function automatic void deque_apply(in_item_t it);
        logic [5:0] slot;
        int i;
        case (it.command)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (count >= CAP)
                    add_expected(mk_result(0, ST_FULL, 1'b1));
                else if (it.command == CMD_PUSH_BACK)
                begin
                    slot = head + count[5:0];
                    ring[slot] = it.value;
                    count++;
                end
                else
                begin
                    head = head - 6'd1;
                    ring[head] = it.value;
                    count++;
                end
            end
            CMD_POP_FRONT:
                if (count > 0)
                begin
                    head = head + 6'd1;
                    count--;
                end
            CMD_POP_BACK:
                if (count > 0)
                    count--;
            CMD_RESIZE:
                if (it.new_length > CAP)
                    add_expected(mk_result(0, ST_BAD, 1'b1));
                else
                begin
                    for (i = count; i < it.new_length; i++)
                    begin
                        slot = head + i[5:0];
                        ring[slot] = '0;
                    end
                    count = it.new_length;
                end
            CMD_READ, CMD_WRITE:
                if (it.position >= count)
                    add_expected(mk_result(0, ST_BAD, 1'b1));
                else
                begin
                    slot = head + it.position;
                    if (it.command == CMD_READ)
                        add_expected(mk_result(ring[slot], ST_READ, 1'b1));
                    else
                        ring[slot] = it.value;
                end
            default:
                if (count == 0)
                    add_expected(mk_result(0, ST_EMPTY, 1'b1));
                else
                    for (i = 0; i < count; i++)
                    begin
                        slot = head + i[5:0];
                        add_expected(mk_result(ring[slot], ST_DUMP, (i + 1 == count)));
                    end
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_cmd(in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_in.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_in.valid <= 1'b1;
        cmd_in.payload <= it;
        @(posedge clk);
        while (!cmd_in.ready)
            @(posedge clk);
        deque_apply(it);
        @(negedge clk);
    endtask

    function automatic in_item_t random_cmd();
        in_item_t it;
        int r;
        r = $urandom_range(99);
        it.value = $urandom;
        it.position = (count > 0 && r % 3 != 0) ? 6'($urandom_range(count - 1))
                                                 : 6'($urandom);
        it.new_length = (r % 7 == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(CAP));
        if (r < 30)
            it.command = CMD_PUSH_BACK;
        else if (r < 45)
            it.command = CMD_PUSH_FRONT;
        else if (r < 53)
            it.command = CMD_POP_FRONT;
        else if (r < 60)
            it.command = CMD_POP_BACK;
        else if (r < 64)
            it.command = CMD_RESIZE;
        else if (r < 80)
            it.command = CMD_READ;
        else if (r < 93)
            it.command = CMD_WRITE;
        else
            it.command = CMD_DUMP;
        if (it.command == CMD_RESIZE && count > 20 && r % 7 != 0)
            it.new_length = 7'($urandom_range(16));
        return it;
    endfunction

    function automatic void add_row(cmd_t c, logic [31:0] v, logic [5:0] p,
                                    logic [6:0] n, bit k, out_item_t e);
        cmd_row_t row;
        row.command = c;
        row.value = v;
        row.position = p;
        row.new_length = n;
        row.has_known = k;
        row.known = e;
        rows = {rows, row};
    endfunction

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            if (got_count >= expected_q.size())
            begin
                $error("unexpected result data=%h status=%0d", res_out.payload.data,
                       res_out.payload.status);
                errors++;
            end
            else
            begin
                exp_r = expected_q[got_count];
                got_count++;
                if (res_out.payload.data !== exp_r.data)
                begin
                    $error("data expected %h actual %h", exp_r.data, res_out.payload.data);
                    errors++;
                end
                if (res_out.payload.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status,
                           res_out.payload.status);
                    errors++;
                end
                if (res_out.payload.last !== exp_r.last)
                begin
                    $error("last expected %0d actual %0d", exp_r.last, res_out.payload.last);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        res_out.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((cmd_in.valid && cmd_in.ready) || (res_out.valid && res_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("deque_with_indexed_access_top_tb failed");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        out_item_t none;
        int n;
        int phase;
        int k;
        none = '0;
        table_errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        head = '0;
        count = '0;
        rst_n = 1'b0;
        cmd_in.valid = 1'b0;
        cmd_in.payload = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        add_row(CMD_DUMP, 0, 0, 0, 1, mk_result(0, ST_EMPTY, 1'b1));
        add_row(CMD_POP_FRONT, 0, 0, 0, 0, none);
        add_row(CMD_POP_BACK, 0, 0, 0, 0, none);
        add_row(CMD_READ, 0, 0, 0, 1, mk_result(0, ST_BAD, 1'b1));
        add_row(CMD_WRITE, 32'h1234, 6'd63, 0, 1, mk_result(0, ST_BAD, 1'b1));
        add_row(CMD_RESIZE, 0, 0, 7'd65, 1, mk_result(0, ST_BAD, 1'b1));
        add_row(CMD_RESIZE, 0, 0, 7'd127, 1, mk_result(0, ST_BAD, 1'b1));
        add_row(CMD_PUSH_BACK, 32'h7fffffff, 0, 0, 0, none);
        add_row(CMD_PUSH_FRONT, 32'h80000000, 0, 0, 0, none);
        add_row(CMD_PUSH_BACK, 32'hffffffff, 0, 0, 0, none);
        add_row(CMD_READ, 0, 6'd0, 0, 1, mk_result(32'h80000000, ST_READ, 1'b1));
        add_row(CMD_WRITE, 32'h00000000, 6'd1, 0, 0, none);
        add_row(CMD_READ, 0, 6'd3, 0, 1, mk_result(0, ST_BAD, 1'b1));
        add_row(CMD_DUMP, 0, 0, 0, 0, none);
        add_row(CMD_POP_FRONT, 0, 0, 0, 0, none);
        add_row(CMD_POP_BACK, 0, 0, 0, 0, none);
        add_row(CMD_RESIZE, 0, 0, 7'd64, 0, none);
        add_row(CMD_PUSH_BACK, 32'h5a5a5a5a, 0, 0, 1, mk_result(0, ST_FULL, 1'b1));
        add_row(CMD_PUSH_FRONT, 32'ha5a5a5a5, 0, 0, 1, mk_result(0, ST_FULL, 1'b1));
        add_row(CMD_WRITE, 32'hdeadbeef, 6'd63, 0, 0, none);
        add_row(CMD_READ, 0, 6'd63, 0, 1, mk_result(32'hdeadbeef, ST_READ, 1'b1));
        add_row(CMD_DUMP, 0, 0, 0, 0, none);
        add_row(CMD_RESIZE, 0, 0, 7'd2, 0, none);
        add_row(CMD_DUMP, 0, 0, 0, 0, none);
        foreach (rows[i])
        begin
            it.command = rows[i].command;
            it.value = rows[i].value;
            it.position = rows[i].position;
            it.new_length = rows[i].new_length;
            n = expected_q.size();
            send_cmd(it);
            if (rows[i].has_known && (expected_q.size() != n + 1
                || expected_q[n] !== rows[i].known))
            begin
                $error("row %0d expected %p", i, rows[i].known);
                table_errors++;
            end
        end
        cmd_in.valid <= 1'b0;

        // pause until all results are back
        while (got_count != expected_q.size())
            @(negedge clk);

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 54 : 28) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 54 : 28) : 0;
            for (k = 0; k < 34; k++)
                send_cmd(random_cmd());
        end
        cmd_in.valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;

        while (got_count != expected_q.size())
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && table_errors == 0 && got_count == expected_q.size())
            $display("deque_with_indexed_access_top_tb passed");
        else
            $display("deque_with_indexed_access_top_tb failed");
        $finish;
    end
endmodule
